FILE: rtl/core/fvn_pkg.sv
// Shared types and constants for the fractal value noise pipeline.
package fvn_pkg;

  // Octave sum never leaves about +-2^31, two guard bits on top.
  localparam int SUM_W = 34;

  localparam logic [31:0] HASH_K    = 32'd2654435761;
  localparam logic [31:0] HASH_Y    = 32'd57;
  localparam logic [31:0] HASH_SQ   = 32'd15731;
  localparam logic [31:0] HASH_ADD  = 32'd789221;
  localparam logic [31:0] HASH_FIN  = 32'd1376312589;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Number of register stages in one octave cell.
  localparam int CELL_LAT = 11;

  typedef enum logic [1:0] {
    REG_SEED    = 2'd0,
    REG_OCTAVES = 2'd1,
    REG_RIDGE   = 2'd2
  } reg_idx_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic                    vld;
    logic [31:0]             x;
    logic [31:0]             y;
    logic signed [SUM_W-1:0] sum;
  } link_t;

endpackage

FILE: rtl/core/fvn_cell.sv
// One octave of value noise: lattice hash, smoothstep blend, add into the running sum.
module fvn_cell #(
  parameter int IDX           = 0,
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          active,
  input  logic [31:0]   seed,
  input  fvn_pkg::link_t link_in,
  output fvn_pkg::link_t link_out
);
  import fvn_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int PW = F + 34;

  link_t a_l, b_l, c_l, d_l, e_l, f_l, g_l, h_l, i_l, j_l, k_l;

  // stage A: lattice cell, fraction, seed product
  logic [63:0] px, py;
  logic [31:0] seed_i;
  logic [31:0] a_xi, a_yi, a_sk;
  logic [F-1:0] a_tx, a_ty;

  assign px     = {{32{link_in.x[31]}}, link_in.x} << IDX;
  assign py     = {{32{link_in.y[31]}}, link_in.y} << IDX;
  assign seed_i = seed + 32'(IDX);

  // stage B: corner hash seeds, t squared
  logic [31:0] b_n [4];
  logic [F-1:0] b_tx, b_ty, b_t2x, b_t2y;
  logic [2*F-1:0] sqx, sqy;
  assign sqx = a_tx * a_tx;
  assign sqy = a_ty * a_ty;

  // stage C: n*n, smoothstep
  logic [31:0] c_n [4];
  logic [31:0] c_nn [4];
  logic [F-1:0] c_sx, c_sy;
  logic [F+1:0] kx, ky;
  logic [2*F+1:0] smx, smy;
  assign kx  = {2'b11, F'(0)} - {1'b0, b_tx, 1'b0};
  assign ky  = {2'b11, F'(0)} - {1'b0, b_ty, 1'b0};
  assign smx = b_t2x * kx;
  assign smy = b_t2y * ky;

  // stage D/E/F: rest of the hash
  logic [31:0] d_n [4];
  logic [31:0] d_q [4];
  logic [F-1:0] d_sx, d_sy;
  logic [31:0] e_w [4];
  logic [F-1:0] e_sx, e_sy;
  logic signed [31:0] f_h [4];
  logic [F-1:0] f_sx, f_sy;

  // stage G/H: x blends
  logic signed [32:0] dx0, dx1;
  logic signed [F:0] sxs, sys;
  logic signed [31:0] g_h00, g_h01;
  logic signed [PW-1:0] g_d0, g_d1;
  logic [F-1:0] g_sy, h_sy;
  logic signed [PW-1:0] sh0, sh1;
  logic signed [31:0] h_e0, h_e1;
  assign dx0 = {f_h[1][31], f_h[1]} - {f_h[0][31], f_h[0]};
  assign dx1 = {f_h[3][31], f_h[3]} - {f_h[2][31], f_h[2]};
  assign sxs = $signed({1'b0, f_sx});
  assign sh0 = g_d0 >>> F;
  assign sh1 = g_d1 >>> F;

  // stage I/J/K: y blend, octave weight
  logic signed [32:0] dy;
  logic signed [31:0] i_e0;
  logic signed [PW-1:0] i_d, shy;
  logic signed [31:0] j_v;
  logic signed [SUM_W-1:0] j_ext, j_sh;
  logic signed [SUM_W-1:0] term;
  assign sys   = $signed({1'b0, h_sy});
  assign dy    = {h_e1[31], h_e1} - {h_e0[31], h_e0};
  assign shy   = i_d >>> F;
  assign j_ext = {{(SUM_W-32){j_v[31]}}, j_v};
  assign j_sh  = j_ext >>> IDX;
  assign term  = active ? j_sh : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_l <= '0; b_l <= '0; c_l <= '0; d_l <= '0; e_l <= '0; f_l <= '0;
      g_l <= '0; h_l <= '0; i_l <= '0; j_l <= '0; k_l <= '0;
    end else if (en) begin
      a_l <= link_in;
      b_l <= a_l; c_l <= b_l; d_l <= c_l; e_l <= d_l; f_l <= e_l;
      g_l <= f_l; h_l <= g_l; i_l <= h_l; j_l <= i_l;
      k_l.vld <= j_l.vld;
      k_l.x   <= j_l.x;
      k_l.y   <= j_l.y;
      k_l.sum <= j_l.sum + term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_xi <= px[F+31:F];
      a_yi <= py[F+31:F];
      a_tx <= px[F-1:0];
      a_ty <= py[F-1:0];
      a_sk <= seed_i * HASH_K;

      for (int c = 0; c < 4; c++) begin
        b_n[c] <= ((a_xi + 32'(c % 2)) + (a_yi + 32'(c / 2)) * HASH_Y + a_sk)
                ^ (((a_xi + 32'(c % 2)) + (a_yi + 32'(c / 2)) * HASH_Y + a_sk) << 13);
      end
      b_tx  <= a_tx;
      b_ty  <= a_ty;
      b_t2x <= sqx[2*F-1:F];
      b_t2y <= sqy[2*F-1:F];

      for (int c = 0; c < 4; c++) begin
        c_n[c]  <= b_n[c];
        c_nn[c] <= b_n[c] * b_n[c];
        d_n[c]  <= c_n[c];
        d_q[c]  <= c_nn[c] * HASH_SQ + HASH_ADD;
        e_w[c]  <= d_n[c] * d_q[c];
        f_h[c]  <= ONE_Q30 - $signed({1'b0, 31'(e_w[c] + HASH_FIN)});
      end
      c_sx <= smx[2*F-1:F];
      c_sy <= smy[2*F-1:F];
      d_sx <= c_sx; d_sy <= c_sy;
      e_sx <= d_sx; e_sy <= d_sy;
      f_sx <= e_sx; f_sy <= e_sy;

      g_h00 <= f_h[0];
      g_h01 <= f_h[2];
      g_d0  <= dx0 * sxs;
      g_d1  <= dx1 * sxs;
      g_sy  <= f_sy;

      h_e0 <= g_h00 + sh0[31:0];
      h_e1 <= g_h01 + sh1[31:0];
      h_sy <= g_sy;

      i_e0 <= h_e0;
      i_d  <= dy * sys;

      j_v <= i_e0 + shy[31:0];
    end
  end

  assign link_out = k_l;

endmodule

FILE: rtl/core/fvn_norm.sv
// Normalization of the octave sum by the reciprocal table entry, saturation, ridge fold.
module fvn_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [fvn_pkg::SUM_W-1:0] sum,
  input  logic [30:0]                     recip,
  input  logic                            ridge,
  output logic                            out_vld,
  output logic [31:0]                     out_val
);
  import fvn_pkg::*;

  localparam int PP_W = SUM_W + 17;
  localparam int TOT_W = PP_W + 17;

  logic v1, v2;
  logic signed [PP_W-1:0] p_hi, p_lo;
  logic signed [TOT_W-1:0] tot;
  logic signed [TOT_W-1:0] r;
  logic signed [31:0] sat, mag, fin;

  assign r = tot >>> 30;

  always_comb begin
    priority if (r > TOT_W'(32'sd1073741824)) sat = ONE_Q30;
    else if (r < -TOT_W'(32'sd1073741824)) sat = -ONE_Q30;
    else sat = r[31:0];
    mag = sat[31] ? -sat : sat;
    fin = ridge ? ONE_Q30 - mag : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end

  // reciprocal split into a 15-bit and a 16-bit half to keep the multipliers narrow
  always_ff @(posedge clk) begin
    if (en) begin
      p_hi <= sum * $signed({2'b00, recip[30:16]});
      p_lo <= sum * $signed({1'b0, recip[15:0]});
      tot  <= (TOT_W'(p_hi) <<< 16) + TOT_W'(p_lo) + (TOT_W'(1) <<< 29);
      out_val <= fin;
    end
  end

endmodule

FILE: rtl/core/fractal_value_noise.sv
// Fractal value noise top level: config port, octave chain, normalization, output skid.
//
// Input channel: coord_x / coord_y (signed, FRACTION_BITS fraction bits) with
// in_valid / in_stall; a request is taken when in_valid is high and in_stall low.
// Output channel: noise_value (signed Q1.30) with out_valid / out_stall.
// One result per request, in request order.
// Throughput: one request per cycle while in_stall is low. A request passes from
// acceptance to out_valid through the chain of octave cells (11 stages each),
// then three normalization stages and the output register.
// Every cell is always in the chain; cells at or beyond the effective octave
// count (zero acts as one) pass the sum through unchanged.
// Config: APB-style, noise_seed at 0x0, octave_count at 0x4, ridge_mode at 0x8.
// Write only while idle. pready is tied high.
// Reset (rst, synchronous): pipeline emptied, noise_seed 0, octave_count 4,
// ridge_mode 0.
// Receiver stall: the output holds its result; one more result is caught in a
// skid register, after which in_stall rises and the whole chain holds until the
// skid drains.
module fractal_value_noise #(
  parameter int MAX_OCTAVES   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] noise_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fvn_pkg::*;

  localparam int NW = $clog2(MAX_OCTAVES + 1);
  localparam int IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic        ridge_mode;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed   <= '0;
      octave_count <= 4'd4;
      ridge_mode   <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_SEED:    noise_seed   <= pwdata;
        REG_OCTAVES: octave_count <= pwdata[3:0];
        REG_RIDGE:   ridge_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SEED:    prdata = noise_seed;
      REG_OCTAVES: prdata = {28'd0, octave_count};
      REG_RIDGE:   prdata = {31'd0, ridge_mode};
      default:     prdata = '0;
    endcase
  end

  // effective octave count: zero acts as one, clamp at the chain length
  logic [NW-1:0] n_eff;
  always_comb begin
    priority if (octave_count == 4'd0) n_eff = NW'(1);
    else if (int'(octave_count) > MAX_OCTAVES) n_eff = NW'(MAX_OCTAVES);
    else n_eff = NW'(octave_count);
  end

  // round(2^(29+n) / (2^n - 1))
  logic [30:0] rom_tbl [2**IW];
  for (genvar g = 0; g < 2**IW; g++) begin : g_rom
    if (g < MAX_OCTAVES) begin : g_ent
      localparam logic [63:0] RV =
        ((64'd1 << (30 + g + 1)) + (64'd1 << (g + 1)) - 64'd1)
        / ((64'd2 << (g + 1)) - 64'd2);
      assign rom_tbl[g] = RV[30:0];
    end else begin : g_pad
      assign rom_tbl[g] = '0;
    end
  end

  logic        skid_valid;
  logic [31:0] skid_data;
  logic        en;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  link_t links [MAX_OCTAVES+1];
  assign links[0].vld = in_valid;
  assign links[0].x   = coord_x;
  assign links[0].y   = coord_y;
  assign links[0].sum = '0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(
      .IDX(g),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .active(NW'(g) < n_eff),
      .seed(noise_seed),
      .link_in(links[g]),
      .link_out(links[g+1])
    );
  end

  logic        lv;
  logic [31:0] ld;

  fvn_norm u_norm (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_vld(links[MAX_OCTAVES].vld),
    .sum(links[MAX_OCTAVES].sum),
    .recip(rom_tbl[IW'(n_eff - NW'(1))]),
    .ridge(ridge_mode),
    .out_vld(lv),
    .out_val(ld)
  );

  logic        take;
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          noise_value <= skid_data;
          out_valid   <= 1'b1;
          skid_valid  <= 1'b0;
        end
      end else if (lv) begin
        if (take) begin
          noise_value <= ld;
          out_valid   <= 1'b1;
        end else begin
          skid_data  <= ld;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (lv && !skid_valid && out_valid && out_stall) |=>
      (skid_valid && skid_data == $past(ld)))
    else $error("result from the chain lost during stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && noise_value == $past(skid_data)))
    else $error("skid result not moved to output");

endmodule
